[design/bpfa_pkg.sv]
// ----------------------------------------------------------------------------
// bpfa_pkg
// Shared types and constants for the bitmap page-frame allocator.
// ----------------------------------------------------------------------------
package bpfa_pkg;

    // page geometry and result codes
    localparam int unsigned PAGE_SHIFT = 12;
    localparam logic [31:0] NO_FRAME   = 32'hFFFF_FFFF;

    // command codes
    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    // status codes
    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_NO_FREE   = 2'd1;
    localparam logic [1:0] STATUS_OUT_RANGE = 2'd2;

    // configuration register indexes
    localparam int unsigned CFG_IDX_W        = 1;
    localparam int unsigned CFG_DATA_W       = 16;
    localparam logic        CFG_BASE_FRAME   = 1'b0;
    localparam logic        CFG_TOTAL_FRAMES = 1'b1;

    // configuration reset values
    localparam logic [15:0] BASE_FRAME_RST   = 16'd0;
    localparam logic [12:0] TOTAL_FRAMES_RST = 13'd4096;

    // input item
    typedef struct packed {
        logic        cmd;
        logic [31:0] free_address;
    } t_in;

    // result item
    typedef struct packed {
        logic [31:0] frame_address;
        logic [1:0]  status;
    } t_out;

    // controller states
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_FREE_Q,
        ST_FREE_WR,
        ST_ADDR,
        ST_DONE
    } t_state;

endpackage

[design/bitmap_page_frame_allocator.sv]
// ----------------------------------------------------------------------------
// bitmap_page_frame_allocator
// Allocates and frees 4 KiB page frames tracked in a used-bit map memory.
// ----------------------------------------------------------------------------
// Usage:
//  - input channel (i_valid / o_stall, i_data): allocate or free command plus
//    the byte address to free; one command is worked on at a time
//  - output channel (o_valid / i_stall, o_data): one result per command, held
//    in an output register while i_stall is high
//  - config channel (i_cfg_valid / o_cfg_ready): base_frame and total_frames,
//    always ready; write only while the block is idle
// Steps from the command transfer to the loaded output register:
//  - allocate: ST_SCAN reads w map words one per cycle (1 up to DEPTH, 128 by
//    default), then ST_ADDR and ST_DONE; ST_SCAN goes to ST_DONE if none is free
//  - zero frames, out-of-range free: ST_DONE; free: ST_FREE_Q, ST_FREE_WR, ST_DONE
// The next command is taken only after ST_DONE; while a stalled result sits
// in the output register the finished command waits and o_stall stays high
// Reset: the map is cleared one word per cycle with o_stall high
// ----------------------------------------------------------------------------
module bitmap_page_frame_allocator #(
    parameter int unsigned MAX_FRAMES    = 4096,
    parameter int unsigned MAP_WORD_BITS = 32
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // command channel
    input  logic                                i_valid,
    output logic                                o_stall,
    input  bpfa_pkg::t_in                       i_data,
    // result channel
    output logic                                o_valid,
    input  logic                                i_stall,
    output bpfa_pkg::t_out                      o_data,
    // config channel
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [bpfa_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [bpfa_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    // derived geometry
    localparam int unsigned DEPTH  = (MAX_FRAMES + MAP_WORD_BITS - 1) / MAP_WORD_BITS;
    localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned BIT_W  = $clog2(MAP_WORD_BITS);
    localparam int unsigned FIDX_W = $clog2(MAX_FRAMES);
    localparam int unsigned LIM_W  = $clog2(MAX_FRAMES + 1);
    localparam int unsigned CW     = ((LIM_W > BIT_W) ? LIM_W : BIT_W) + 1;
    localparam int unsigned SUM_W  = ((FIDX_W > BIT_W) ? FIDX_W : BIT_W) + 1;
    // reciprocal for the word index of a free: exact for all offsets below 2^FIDX_W
    localparam int unsigned SH     = FIDX_W + 2 * BIT_W;
    localparam int unsigned PW     = FIDX_W + SH;
    localparam logic [63:0] RECIP_L =
        ((64'd1 << SH) + 64'(MAP_WORD_BITS) - 64'd1) / 64'(MAP_WORD_BITS);
    localparam logic [SH-1:0] RECIP = SH'(RECIP_L);

    // used-bit map memory
    logic [MAP_WORD_BITS-1:0] r_map [DEPTH];
    logic [MAP_WORD_BITS-1:0] r_rd_data;
    logic                     mem_we;
    logic [ADDR_W-1:0]        mem_waddr;
    logic [MAP_WORD_BITS-1:0] mem_wdata;
    logic                     mem_re;
    logic [ADDR_W-1:0]        mem_raddr;

    // configuration
    logic [15:0]              r_base;
    logic [12:0]              r_total;
    logic [LIM_W-1:0]         limit;

    // control and datapath registers
    bpfa_pkg::t_state         r_state, n_state;
    logic [ADDR_W-1:0]        r_clr_idx, n_clr_idx;
    logic [ADDR_W-1:0]        r_rd_idx, n_rd_idx;
    logic [FIDX_W-1:0]        r_word_base, n_word_base;
    logic [LIM_W-1:0]         r_left, n_left;
    logic [FIDX_W-1:0]        r_off, n_off;
    logic [FIDX_W-1:0]        r_found_idx, n_found_idx;
    logic [31:0]              r_res_addr, n_res_addr;
    logic [1:0]               r_res_status, n_res_status;
    logic                     r_out_valid, n_out_valid;
    bpfa_pkg::t_out           r_out_data, n_out_data;

    // scan and free helpers
    logic [MAP_WORD_BITS-1:0] free_vec;
    logic                     found;
    logic [BIT_W-1:0]         found_bit;
    logic                     last_word;
    logic [19:0]              fnum;
    logic [20:0]              off_full;
    logic                     free_bad;
    logic [PW-1:0]            prod;
    logic [ADDR_W-1:0]        q_word;
    logic [FIDX_W-1:0]        rem_off;
    logic [BIT_W-1:0]         free_bit;
    logic                     in_xfer;

    assign o_cfg_ready = 1'b1;
    assign o_stall     = (r_state != bpfa_pkg::ST_IDLE);
    assign o_valid     = r_out_valid;
    assign o_data      = r_out_data;
    assign in_xfer     = i_valid && (r_state == bpfa_pkg::ST_IDLE);

    // effective frame count
    assign limit = (32'(r_total) > 32'(MAX_FRAMES)) ? LIM_W'(MAX_FRAMES) : LIM_W'(r_total);

    // config register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base  <= bpfa_pkg::BASE_FRAME_RST;
            r_total <= bpfa_pkg::TOTAL_FRAMES_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                bpfa_pkg::CFG_BASE_FRAME:   r_base  <= i_cfg_data;
                bpfa_pkg::CFG_TOTAL_FRAMES: r_total <= i_cfg_data[12:0];
                default:                    r_total <= r_total;
            endcase
        end
    end

    // map memory, one write and one registered read port
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_map[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rd_data <= r_map[mem_raddr];
        end
    end

    // lowest free bit of the current word, bits beyond the frame count count as used
    always_comb begin
        found_bit = '0;
        for (int b = 0; b < MAP_WORD_BITS; b++) begin
            free_vec[b] = !r_rd_data[b] && (CW'(b) < CW'(r_left));
        end
        for (int b = MAP_WORD_BITS - 1; b >= 0; b--) begin
            if (free_vec[b]) begin
                found_bit = BIT_W'(b);
            end
        end
    end
    assign found     = |free_vec;
    assign last_word = (CW'(r_left) <= CW'(MAP_WORD_BITS));

    // free address range check
    assign fnum     = i_data.free_address[31:bpfa_pkg::PAGE_SHIFT];
    assign off_full = 21'(fnum) - 21'(r_base);
    assign free_bad = (fnum < 20'(r_base)) || (off_full >= 21'(limit));

    // word index and bit position of a free
    assign prod     = PW'(r_off) * PW'(RECIP);
    assign q_word   = ADDR_W'(prod >> SH);
    assign rem_off  = r_off - FIDX_W'(32'(r_rd_idx) * MAP_WORD_BITS);
    assign free_bit = BIT_W'(rem_off);

    // next state, memory control and result
    always_comb begin
        n_state      = r_state;
        n_clr_idx    = r_clr_idx;
        n_rd_idx     = r_rd_idx;
        n_word_base  = r_word_base;
        n_left       = r_left;
        n_off        = r_off;
        n_found_idx  = r_found_idx;
        n_res_addr   = r_res_addr;
        n_res_status = r_res_status;
        n_out_valid  = r_out_valid && i_stall;
        n_out_data   = r_out_data;
        mem_we       = 1'b0;
        mem_waddr    = r_rd_idx;
        mem_wdata    = r_rd_data;
        mem_re       = 1'b0;
        mem_raddr    = r_rd_idx;

        unique case (r_state)
            // clearing pass after reset
            bpfa_pkg::ST_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = r_clr_idx;
                mem_wdata = '0;
                if (r_clr_idx == ADDR_W'(DEPTH - 1)) begin
                    n_state = bpfa_pkg::ST_IDLE;
                end else begin
                    n_clr_idx = r_clr_idx + 1'b1;
                end
            end

            // take a command
            bpfa_pkg::ST_IDLE: begin
                if (in_xfer) begin
                    if (i_data.cmd == bpfa_pkg::CMD_ALLOC) begin
                        if (limit == '0) begin
                            n_res_addr   = bpfa_pkg::NO_FRAME;
                            n_res_status = bpfa_pkg::STATUS_NO_FREE;
                            n_state      = bpfa_pkg::ST_DONE;
                        end else begin
                            mem_re      = 1'b1;
                            mem_raddr   = '0;
                            n_rd_idx    = '0;
                            n_word_base = '0;
                            n_left      = limit;
                            n_state     = bpfa_pkg::ST_SCAN;
                        end
                    end else begin
                        n_res_addr = bpfa_pkg::NO_FRAME;
                        if (free_bad) begin
                            n_res_status = bpfa_pkg::STATUS_OUT_RANGE;
                            n_state      = bpfa_pkg::ST_DONE;
                        end else begin
                            n_res_status = bpfa_pkg::STATUS_OK;
                            n_off        = FIDX_W'(off_full);
                            n_state      = bpfa_pkg::ST_FREE_Q;
                        end
                    end
                end
            end

            // one map word per cycle
            bpfa_pkg::ST_SCAN: begin
                if (found) begin
                    mem_we      = 1'b1;
                    mem_waddr   = r_rd_idx;
                    mem_wdata   = r_rd_data | (MAP_WORD_BITS'(1) << found_bit);
                    n_found_idx = FIDX_W'(SUM_W'(r_word_base) + SUM_W'(found_bit));
                    n_state     = bpfa_pkg::ST_ADDR;
                end else if (last_word) begin
                    n_res_addr   = bpfa_pkg::NO_FRAME;
                    n_res_status = bpfa_pkg::STATUS_NO_FREE;
                    n_state      = bpfa_pkg::ST_DONE;
                end else begin
                    mem_re      = 1'b1;
                    mem_raddr   = r_rd_idx + 1'b1;
                    n_rd_idx    = r_rd_idx + 1'b1;
                    n_word_base = FIDX_W'(SUM_W'(r_word_base) + SUM_W'(MAP_WORD_BITS));
                    n_left      = LIM_W'(CW'(r_left) - CW'(MAP_WORD_BITS));
                end
            end

            // frame byte address of the allocated frame
            bpfa_pkg::ST_ADDR: begin
                n_res_addr   = (32'(r_base) + 32'(r_found_idx)) << bpfa_pkg::PAGE_SHIFT;
                n_res_status = bpfa_pkg::STATUS_OK;
                n_state      = bpfa_pkg::ST_DONE;
            end

            // word index of the freed frame, read that word
            bpfa_pkg::ST_FREE_Q: begin
                mem_re    = 1'b1;
                mem_raddr = q_word;
                n_rd_idx  = q_word;
                n_state   = bpfa_pkg::ST_FREE_WR;
            end

            // clear the bit and write back
            bpfa_pkg::ST_FREE_WR: begin
                mem_we    = 1'b1;
                mem_waddr = r_rd_idx;
                mem_wdata = r_rd_data & ~(MAP_WORD_BITS'(1) << free_bit);
                n_state   = bpfa_pkg::ST_DONE;
            end

            // hand the result to the output register
            bpfa_pkg::ST_DONE: begin
                if (!r_out_valid || !i_stall) begin
                    n_out_valid              = 1'b1;
                    n_out_data.frame_address = r_res_addr;
                    n_out_data.status        = r_res_status;
                    n_state                  = bpfa_pkg::ST_IDLE;
                end
            end

            default: begin
                n_state = bpfa_pkg::ST_IDLE;
            end
        endcase
    end

    // state and control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= bpfa_pkg::ST_CLEAR;
            r_clr_idx   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_idx   <= n_clr_idx;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_rd_idx     <= n_rd_idx;
        r_word_base  <= n_word_base;
        r_left       <= n_left;
        r_off        <= n_off;
        r_found_idx  <= n_found_idx;
        r_res_addr   <= n_res_addr;
        r_res_status <= n_res_status;
        r_out_data   <= n_out_data;
    end

endmodule

[tb/sv/bitmap_page_frame_allocator_test.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bitmap_page_frame_allocator_test
// Self-checking bench for the page-frame allocator: a queue-fed driver offers
// allocate and free commands, a shadow used-bit map predicts every result,
// and a monitor compares each result transfer against the oldest prediction
// over several base/count settings and idle patterns.
// ----------------------------------------------------------------------------
module bitmap_page_frame_allocator_test;

    localparam int unsigned MAX_FRAMES    = 4096;
    localparam int unsigned MAP_WORD_BITS = 32;
    localparam int unsigned PHASES        = 12;
    localparam int unsigned PHASE_CMDS    = 140;
    localparam int unsigned HOLD_CYCLES   = 400;
    localparam int unsigned DRAIN_CYCLES  = 200;

    typedef enum logic [1:0] {
        IDLE_NONE,
        IDLE_SEND,
        IDLE_RECV,
        IDLE_BOTH
    } t_idle_mode;

    // block ports
    logic                            i_clk       = 1'b0;
    logic                            i_rst_n     = 1'b0;
    logic                            i_valid     = 1'b0;
    logic                            o_stall;
    bpfa_pkg::t_in                   i_data      = '0;
    logic                            o_valid;
    logic                            i_stall     = 1'b0;
    bpfa_pkg::t_out                  o_data;
    logic                            i_cfg_valid = 1'b0;
    logic                            o_cfg_ready;
    logic [bpfa_pkg::CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [bpfa_pkg::CFG_DATA_W-1:0] i_cfg_data  = '0;

    // shadow allocator state
    logic        frame_used [0:MAX_FRAMES-1];
    logic [15:0] cfg_base;
    logic [12:0] cfg_total;

    // stimulus and expectation stores
    bpfa_pkg::t_in  cmd_queue[$];
    bpfa_pkg::t_out frame_result_queue[$];
    t_idle_mode     idle_mode = IDLE_NONE;
    logic           cmd_taken = 1'b0;
    logic           hold_req  = 1'b0;
    int unsigned    hold_left = 0;
    int unsigned    mismatch_count = 0;

    bpfa_pkg::t_out exp_result;
    int unsigned    ph;
    int unsigned    n;
    int unsigned    gen_base;
    int unsigned    gen_limit;
    int unsigned    total_pick [0:PHASES-1] =
        '{33, 4096, 1, 64, 8191, 0, 32, 4097, 100, 2, 31, 4095};

    bitmap_page_frame_allocator #(
        .MAX_FRAMES    (MAX_FRAMES),
        .MAP_WORD_BITS (MAP_WORD_BITS)
    ) u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_data      (i_data),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_data      (o_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // clock
    always #6 i_clk = ~i_clk;

    // run limit
    initial begin
        #15_000_000;
        $display("[bitmap_page_frame_allocator] ERROR");
        $finish;
    end

    // expected result of one command, updates the shadow map
    function automatic bpfa_pkg::t_out predict_frame_result(input bpfa_pkg::t_in item);
        bpfa_pkg::t_out res;
        int unsigned    limit;
        int unsigned    fnum;
        int unsigned    idx;
        logic           found;
        res.frame_address = bpfa_pkg::NO_FRAME;
        res.status        = bpfa_pkg::STATUS_OK;
        limit = (cfg_total > MAX_FRAMES) ? MAX_FRAMES : cfg_total;
        found = 1'b0;
        if (item.cmd == bpfa_pkg::CMD_ALLOC) begin
            res.status = bpfa_pkg::STATUS_NO_FREE;
            for (idx = 0; idx < limit && !found; idx++) begin
                if (!frame_used[idx]) begin
                    found             = 1'b1;
                    frame_used[idx]   = 1'b1;
                    res.frame_address =
                        (32'(cfg_base) + 32'(idx)) << bpfa_pkg::PAGE_SHIFT;
                    res.status        = bpfa_pkg::STATUS_OK;
                end
            end
        end else begin
            fnum = item.free_address >> bpfa_pkg::PAGE_SHIFT;
            if (fnum < cfg_base || (fnum - cfg_base) >= limit)
                res.status = bpfa_pkg::STATUS_OUT_RANGE;
            else
                frame_used[fnum - cfg_base] = 1'b0;
        end
        return res;
    endfunction

    function automatic logic idle_roll(input logic rx_side);
        int unsigned pct;
        unique case (idle_mode)
            IDLE_SEND: pct = rx_side ? 0 : 67;
            IDLE_RECV: pct = rx_side ? 67 : 0;
            IDLE_BOTH: pct = 12;
            default:   pct = 0;
        endcase
        return $urandom_range(99) < pct;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("%0t mismatch on %s: got %h, expected %h", $realtime, what, got, want);
        mismatch_count++;
    endtask

    task automatic queue_cmd(input logic cmd, input logic [31:0] addr);
        bpfa_pkg::t_in item;
        item.cmd          = cmd;
        item.free_address = addr;
        cmd_queue.push_back(item);
    endtask

    // mostly allocates and in-range frees, some strays and noise
    task automatic queue_random_cmd(input int unsigned base, input int unsigned limit);
        int unsigned r;
        int unsigned span;
        int unsigned fnum;
        r = $urandom_range(99);
        if (r < 50) begin
            queue_cmd(bpfa_pkg::CMD_ALLOC, $urandom);
        end else if (r < 80 && limit != 0) begin
            span = (limit < 96 || $urandom_range(9) == 0) ? limit : 96;
            fnum = base + $urandom_range(span - 1);
            queue_cmd(bpfa_pkg::CMD_FREE,
                      (fnum << bpfa_pkg::PAGE_SHIFT) | $urandom_range(4095));
        end else if (r < 90) begin
            if (base != 0 && $urandom_range(1) == 0)
                fnum = $urandom_range(base - 1);
            else
                fnum = base + limit + $urandom_range(50);
            queue_cmd(bpfa_pkg::CMD_FREE,
                      (fnum << bpfa_pkg::PAGE_SHIFT) | $urandom_range(4095));
        end else begin
            queue_cmd(bpfa_pkg::CMD_FREE, $urandom);
        end
    endtask

    task automatic write_cfg(input logic [bpfa_pkg::CFG_IDX_W-1:0] idx,
                             input logic [bpfa_pkg::CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // block quiet: nothing queued, offered or outstanding
    task automatic wait_idle;
        @(posedge i_clk);
        while (cmd_queue.size() != 0 || i_valid || frame_result_queue.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // long receiver hold-off
    always @(posedge i_clk) begin
        if (hold_req) begin
            hold_req  = 1'b0;
            hold_left = HOLD_CYCLES;
        end else if (hold_left != 0) begin
            hold_left = hold_left - 1;
        end
    end

    // command driver and result stall, both on the falling edge
    always @(negedge i_clk) begin
        if (!i_valid || cmd_taken) begin
            cmd_taken = 1'b0;
            if (cmd_queue.size() != 0 && !idle_roll(1'b0)) begin
                i_data  <= cmd_queue.pop_front();
                i_valid <= 1'b1;
            end else begin
                i_valid <= 1'b0;
            end
        end
        i_stall <= (hold_left != 0) || idle_roll(1'b1);
    end

    // monitor: config and command transfers feed the shadow, results are checked
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (n = 0; n < MAX_FRAMES; n++) frame_used[n] = 1'b0;
            cfg_base  = bpfa_pkg::BASE_FRAME_RST;
            cfg_total = bpfa_pkg::TOTAL_FRAMES_RST;
            frame_result_queue.delete();
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                if (i_cfg_index == bpfa_pkg::CFG_BASE_FRAME)
                    cfg_base = i_cfg_data;
                else
                    cfg_total = i_cfg_data[12:0];
            end
            if (i_valid && !o_stall) begin
                frame_result_queue.push_back(predict_frame_result(i_data));
                cmd_taken = 1'b1;
            end
            if (o_valid && !i_stall) begin
                if (frame_result_queue.size() == 0) begin
                    report_mismatch("unexpected result", o_data.frame_address,
                                    bpfa_pkg::NO_FRAME);
                end else begin
                    exp_result = frame_result_queue.pop_front();
                    if (o_data.frame_address !== exp_result.frame_address)
                        report_mismatch("frame_address", o_data.frame_address,
                                        exp_result.frame_address);
                    if (o_data.status !== exp_result.status)
                        report_mismatch("status", 32'(o_data.status),
                                        32'(exp_result.status));
                end
            end
        end
    end

    // stimulus sequence
    initial begin
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // small window: fill, exhaust, unaligned, stray and double frees
        write_cfg(bpfa_pkg::CFG_BASE_FRAME, 16'd5);
        write_cfg(bpfa_pkg::CFG_TOTAL_FRAMES, 16'd3);
        repeat (4) queue_cmd(bpfa_pkg::CMD_ALLOC, 32'h0);
        queue_cmd(bpfa_pkg::CMD_FREE, (32'd6 << bpfa_pkg::PAGE_SHIFT) | 32'hFFF);
        queue_cmd(bpfa_pkg::CMD_ALLOC, 32'hFFFF_FFFF);
        queue_cmd(bpfa_pkg::CMD_FREE, 32'd4 << bpfa_pkg::PAGE_SHIFT);
        queue_cmd(bpfa_pkg::CMD_FREE, 32'd8 << bpfa_pkg::PAGE_SHIFT);
        queue_cmd(bpfa_pkg::CMD_FREE, 32'd5 << bpfa_pkg::PAGE_SHIFT);
        queue_cmd(bpfa_pkg::CMD_FREE, 32'd5 << bpfa_pkg::PAGE_SHIFT);
        queue_cmd(bpfa_pkg::CMD_ALLOC, 32'h0);
        queue_cmd(bpfa_pkg::CMD_FREE, 32'hFFFF_FFFF);
        wait_idle();

        // zero frames managed
        write_cfg(bpfa_pkg::CFG_TOTAL_FRAMES, 16'd0);
        queue_cmd(bpfa_pkg::CMD_ALLOC, 32'h0);
        queue_cmd(bpfa_pkg::CMD_FREE, 32'd5 << bpfa_pkg::PAGE_SHIFT);
        wait_idle();

        // top base, frame count above the maximum
        write_cfg(bpfa_pkg::CFG_BASE_FRAME, 16'hFFFF);
        write_cfg(bpfa_pkg::CFG_TOTAL_FRAMES, 16'hFFFF);
        queue_cmd(bpfa_pkg::CMD_ALLOC, 32'h0);
        queue_cmd(bpfa_pkg::CMD_FREE, 32'h0FFF_F000);
        queue_cmd(bpfa_pkg::CMD_FREE, 32'hFFFF_F000);
        queue_cmd(bpfa_pkg::CMD_FREE, 32'h0000_0000);
        queue_cmd(bpfa_pkg::CMD_ALLOC, 32'h0);
        queue_cmd(bpfa_pkg::CMD_ALLOC, 32'h0);

        // random phases over base/count settings and idle patterns
        for (ph = 0; ph < PHASES; ph++) begin
            wait_idle();
            unique case (ph % 4)
                0:       gen_base = 0;
                1:       gen_base = 16'hFFFF;
                2:       gen_base = $urandom_range(300);
                default: gen_base = $urandom_range(16'hFFFF);
            endcase
            gen_limit = (total_pick[ph] > MAX_FRAMES) ? MAX_FRAMES : total_pick[ph];
            write_cfg(bpfa_pkg::CFG_BASE_FRAME, 16'(gen_base));
            write_cfg(bpfa_pkg::CFG_TOTAL_FRAMES, {3'($urandom), 13'(total_pick[ph])});
            idle_mode = t_idle_mode'(ph % 4);
            for (n = 0; n < PHASE_CMDS; n++) queue_random_cmd(gen_base, gen_limit);
            if (ph == 4) hold_req = 1'b1;
        end

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("[bitmap_page_frame_allocator] OK");
        else
            $display("[bitmap_page_frame_allocator] ERROR");
        $finish;
    end

endmodule

[filelist.f]
design/bpfa_pkg.sv
design/bitmap_page_frame_allocator.sv
tb/sv/bitmap_page_frame_allocator_test.sv
